/* design/clia_pkg.sv */
// Shared types, constants and helpers for the lowest-identifier bus arbiter.
`default_nettype none

package clia_pkg;

  // Table geometry
  localparam int ENTRIES = 32;
  localparam int NODES   = 16;
  localparam int ID_BITS = 29;

  // Field widths of the item and result ports
  localparam int KIND_FW = 3;
  localparam int ID_FW   = 29;
  localparam int NODE_FW = 4;
  localparam int CNT_FW  = 6;

  // Internal widths
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int BIT_W  = $clog2(ID_BITS);

  typedef logic [ENTRIES-1:0] ent_vec_t;

  // Item kinds
  typedef enum logic [KIND_FW-1:0] {
    K_REGISTER   = 3'd0,
    K_CHECKOUT   = 3'd1,
    K_ARBITRATE  = 3'd2,
    K_COMPLETE   = 3'd3,
    K_ERROR_END  = 3'd4,
    K_ERROR_SEEN = 3'd5
  } kind_e;

  typedef struct packed {
    logic [KIND_FW-1:0] kind;
    logic [ID_FW-1:0]   can_id;
    logic [NODE_FW-1:0] node;
    logic               is_remote;
  } clia_in_t;

  typedef struct packed {
    logic               grant_valid;
    logic [ID_FW-1:0]   grant_id;
    logic [NODE_FW-1:0] grant_node;
    logic               duplicate_senders;
    logic               error_forwarded;
    logic               table_full;
    logic [CNT_FW-1:0]  entry_count;
    logic               bus_idle;
  } clia_out_t;

  // Table control from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ID_BITS-1:0] wr_id;
    logic [NODE_W-1:0] wr_node;
    logic              wr_remote;
    logic              rotate;
    logic              drop_en;
    ent_vec_t          drop_sel;
    ent_vec_t          mark_set;
    logic              mark_clr;
  } tbl_ctrl_t;

  // Serial search control
  typedef struct packed {
    logic load;
    logic step;
    logic chk;
  } srch_ctrl_t;

  // Lowest set bit of a lane vector, one-hot
  function automatic ent_vec_t first_one(input ent_vec_t x);
    return x & (~x + ent_vec_t'(1));
  endfunction

endpackage

`default_nettype wire

/* design/clia_table.sv */
// Request table: per-entry identifier rotators, node, remote flag and erase mark.
`default_nettype none

module clia_table import clia_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tbl_ctrl_t         ctrl_i,
  input  wire ent_vec_t          sel_i,
  output logic [ENTRIES-1:0]     msb_o,
  output ent_vec_t               remote_o,
  output ent_vec_t               mark_o,
  output logic [NODE_W-1:0]      sel_node_o
);

  logic [ID_BITS-1:0] ident_q [ENTRIES];
  logic [NODE_W-1:0]  node_q  [ENTRIES];
  ent_vec_t           remote_q;
  ent_vec_t           mark_q;

  // Lanes at or above the dropped entry take their upper neighbour
  ent_vec_t drop_ge;
  assign drop_ge = ~(ctrl_i.drop_sel - ent_vec_t'(1));

  genvar g;
  for (g = 0; g < ENTRIES; g++) begin : g_row
    logic [ID_BITS-1:0] up_id;
    logic [NODE_W-1:0]  up_node;
    logic               up_remote;
    logic               up_mark;

    if (g == ENTRIES - 1) begin : g_top
      assign up_id     = ident_q[g];
      assign up_node   = node_q[g];
      assign up_remote = remote_q[g];
      assign up_mark   = 1'b0;
    end else begin : g_mid
      assign up_id     = ident_q[g+1];
      assign up_node   = node_q[g+1];
      assign up_remote = remote_q[g+1];
      assign up_mark   = mark_q[g+1];
    end

    // Entry payload: write, shift down on drop, or rotate one bit
    always_ff @(posedge clk_i) begin
      if (ctrl_i.wr_en && (ctrl_i.wr_idx == IDX_W'(g))) begin
        ident_q[g]  <= ctrl_i.wr_id;
        node_q[g]   <= ctrl_i.wr_node;
        remote_q[g] <= ctrl_i.wr_remote;
      end else if (ctrl_i.drop_en && drop_ge[g]) begin
        ident_q[g]  <= up_id;
        node_q[g]   <= up_node;
        remote_q[g] <= up_remote;
      end else if (ctrl_i.rotate) begin
        ident_q[g]  <= {ident_q[g][ID_BITS-2:0], ident_q[g][ID_BITS-1]};
      end
    end

    // Erase mark travels with its entry
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mark_q[g] <= 1'b0;
      end else if (ctrl_i.mark_clr) begin
        mark_q[g] <= 1'b0;
      end else if (ctrl_i.wr_en && (ctrl_i.wr_idx == IDX_W'(g))) begin
        mark_q[g] <= 1'b0;
      end else if (ctrl_i.drop_en && drop_ge[g]) begin
        mark_q[g] <= up_mark;
      end else if (ctrl_i.mark_set[g]) begin
        mark_q[g] <= 1'b1;
      end
    end

    assign msb_o[g] = ident_q[g][ID_BITS-1];
  end

  assign remote_o = remote_q;
  assign mark_o   = mark_q;

  // One-hot node select
  always_comb begin
    sel_node_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_node_o = sel_node_o | (node_q[i] & {NODE_W{sel_i[i]}});
    end
  end

endmodule

`default_nettype wire

/* design/clia_search.sv */
// Bit-serial identifier search: minimum tracking or equality match, MSB first.
`default_nettype none

module clia_search import clia_pkg::*; (
  input  wire logic               clk_i,
  input  wire srch_ctrl_t         ctrl_i,
  input  wire ent_vec_t           cand_init_i,
  input  wire logic [ID_BITS-1:0] key_i,
  input  wire ent_vec_t           msb_i,
  output ent_vec_t                cand_o,
  output logic [ID_BITS-1:0]      min_id_o
);

  ent_vec_t           cand_q;
  logic [ID_BITS-1:0] key_q;
  logic [ID_BITS-1:0] min_q;

  // Candidates holding a zero in the current bit
  ent_vec_t zeros;
  assign zeros = cand_q & ~msb_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cand_q <= cand_init_i;
      key_q  <= key_i;
    end else if (ctrl_i.step) begin
      if (ctrl_i.chk) begin
        cand_q <= cand_q & ~(msb_i ^ {ENTRIES{key_q[ID_BITS-1]}});
        key_q  <= {key_q[ID_BITS-2:0], key_q[ID_BITS-1]};
      end else begin
        if (|zeros) begin
          cand_q <= zeros;
        end
        min_q <= {min_q[ID_BITS-2:0], ~|zeros};
      end
    end
  end

  assign cand_o   = cand_q;
  assign min_id_o = min_q;

endmodule

`default_nettype wire

/* design/can_lowest_id_arbiter_unit.sv */
// Top level: sequencer, table, serial search and result register.
// Register, error_seen and unused kinds give their result in the cycle after
// acceptance; arbitrate, error_end and checkout run the bit-serial identifier search,
// one bit per cycle, before FINISH registers the result; complete first drops every marked entry.
// Throughput: one item at a time, busy stays high until the result is in the output register.
// Reset clears the entry count, marks and flags; entry contents are left as they are.
// The receiver cannot stall: each result is shown for one cycle on result_valid_o.
`default_nettype none

module can_lowest_id_arbiter_unit import clia_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire clia_in_t  item_i,
  output logic           result_valid_o,
  output clia_out_t      result_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ERASE  = 4'b0010,
    S_SEARCH = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              idle_q, idle_d;
  logic              err_q, err_d;
  logic              chk_q, chk_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic              res_vld_q, res_vld_d;
  clia_out_t         res_q, res_d;

  tbl_ctrl_t          tctl;
  srch_ctrl_t         sctl;
  ent_vec_t           sel;
  ent_vec_t           msb;
  ent_vec_t           remote;
  ent_vec_t           mark;
  logic [NODE_W-1:0]  sel_node;
  ent_vec_t           cand;
  logic [ID_BITS-1:0] min_id;

  ent_vec_t valid;
  ent_vec_t data;
  ent_vec_t data_first;
  ent_vec_t pend_mark;

  clia_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tctl),
    .sel_i      (sel),
    .msb_o      (msb),
    .remote_o   (remote),
    .mark_o     (mark),
    .sel_node_o (sel_node)
  );

  clia_search u_search (
    .clk_i       (clk_i),
    .ctrl_i      (sctl),
    .cand_init_i (valid),
    .key_i       (item_i.can_id[ID_BITS-1:0]),
    .msb_i       (msb),
    .cand_o      (cand),
    .min_id_o    (min_id)
  );

  // Occupied lanes
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid[i] = CNT_W'(i) < count_q;
    end
  end

  assign data       = cand & ~remote;
  assign data_first = first_one(data);
  assign pend_mark  = mark & valid;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idle_d    = idle_q;
    err_d     = err_q;
    chk_d     = chk_q;
    bit_d     = bit_q;
    res_vld_d = 1'b0;
    res_d     = '0;
    tctl      = '0;
    sctl      = '0;
    sel       = '0;

    tctl.wr_idx    = count_q[IDX_W-1:0];
    tctl.wr_id     = item_i.can_id[ID_BITS-1:0];
    tctl.wr_node   = NODE_W'(item_i.node);
    tctl.wr_remote = item_i.is_remote;
    sctl.chk       = chk_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (kind_e'(item_i.kind))
            K_REGISTER: begin
              if (count_q == CNT_W'(ENTRIES)) begin
                res_d.table_full = 1'b1;
              end else begin
                tctl.wr_en = 1'b1;
                count_d    = count_q + CNT_W'(1);
                idle_d     = 1'b0;
              end
              res_vld_d = 1'b1;
            end
            K_CHECKOUT: begin
              sctl.load = 1'b1;
              chk_d     = 1'b1;
              bit_d     = '0;
              state_d   = S_SEARCH;
            end
            K_ARBITRATE: begin
              sctl.load = 1'b1;
              chk_d     = 1'b0;
              bit_d     = '0;
              state_d   = S_SEARCH;
            end
            K_COMPLETE: begin
              err_d   = 1'b0;
              state_d = S_ERASE;
            end
            K_ERROR_END: begin
              err_d         = 1'b0;
              tctl.mark_clr = 1'b1;
              sctl.load     = 1'b1;
              chk_d         = 1'b0;
              bit_d         = '0;
              state_d       = S_SEARCH;
            end
            K_ERROR_SEEN: begin
              if (!err_q) begin
                err_d                 = 1'b1;
                res_d.error_forwarded = 1'b1;
              end
              res_vld_d = 1'b1;
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end

      // Drop the first marked entry each cycle, then search
      S_ERASE: begin
        if (|pend_mark) begin
          tctl.drop_en  = 1'b1;
          tctl.drop_sel = first_one(pend_mark);
          count_d       = count_q - CNT_W'(1);
        end else begin
          sctl.load = 1'b1;
          chk_d     = 1'b0;
          bit_d     = '0;
          state_d   = S_SEARCH;
        end
      end

      // One identifier bit per cycle, MSB first
      S_SEARCH: begin
        sctl.step   = 1'b1;
        tctl.rotate = 1'b1;
        bit_d       = bit_q + BIT_W'(1);
        if (bit_q == BIT_W'(ID_BITS - 1)) begin
          state_d = S_FINISH;
        end
      end

      // Identifiers are back in place: apply the outcome
      S_FINISH: begin
        state_d   = S_IDLE;
        res_vld_d = 1'b1;
        if (chk_q) begin
          if (|cand) begin
            tctl.drop_en  = 1'b1;
            tctl.drop_sel = first_one(cand);
            count_d       = count_q - CNT_W'(1);
          end
        end else if (count_q == '0) begin
          idle_d = 1'b1;
        end else begin
          sel                     = (|data) ? data_first : first_one(cand);
          tctl.mark_set           = (cand & remote) | data_first;
          res_d.grant_valid       = 1'b1;
          res_d.grant_id          = ID_FW'(min_id);
          res_d.grant_node        = NODE_FW'(sel_node);
          res_d.duplicate_senders = |(data & (data - ent_vec_t'(1)));
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.entry_count = CNT_FW'(count_d);
    res_d.bus_idle    = idle_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idle_q    <= 1'b1;
      err_q     <= 1'b0;
      chk_q     <= 1'b0;
      bit_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idle_q    <= idle_d;
      err_q     <= err_d;
      chk_q     <= chk_d;
      bit_q     <= bit_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (res_vld_d) begin
      res_q <= res_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

/* design/clia_checker.sv */
// Port-level checks for the arbiter, bound to the top level.
`default_nettype none

module clia_checker import clia_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start_i,
  input wire logic      busy_i,
  input wire clia_in_t  item_i,
  input wire logic      res_vld_i,
  input wire clia_out_t res_i
);

  // A result only appears once the sequencer is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_i |-> !busy_i)
    else $error("result shown while busy");

  // Items without a search answer in the next cycle (unused kinds sit above error_seen)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && (item_i.kind == K_REGISTER || item_i.kind == K_ERROR_SEEN
      || item_i.kind > K_ERROR_SEEN)) |=> res_vld_i)
    else $error("immediate item gave no result");

  // No grant means zeroed grant fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_i && !res_i.grant_valid) |->
      (res_i.grant_id == '0 && res_i.grant_node == '0 && !res_i.duplicate_senders))
    else $error("grant fields set without grant");

  // A grant needs pending entries and a busy bus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_i && res_i.grant_valid) |-> (!res_i.bus_idle && res_i.entry_count != '0))
    else $error("grant with empty table");

  // Rejection only with a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_i && res_i.table_full) |-> (res_i.entry_count == CNT_FW'(ENTRIES)))
    else $error("table_full below capacity");

endmodule

bind can_lowest_id_arbiter_unit clia_checker u_clia_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start),
  .busy_i    (busy),
  .item_i    (item_i),
  .res_vld_i (result_valid_o),
  .res_i     (result_o)
);

`default_nettype wire

/* test/tb_can_lowest_id_arbiter_unit.sv */
// Self-checking testbench for the lowest-identifier bus arbiter unit.
`timescale 1ns / 100ps

module tb_can_lowest_id_arbiter_unit;
  import clia_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 5;
  localparam int RAND_ITEMS = 550;
  localparam int MAX_GAP = 20;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  // Kinds the block decodes as no-ops
  localparam logic [KIND_FW-1:0] K_SPARE_6 = 3'd6;
  localparam logic [KIND_FW-1:0] K_SPARE_7 = 3'd7;
  localparam logic [ID_FW-1:0] ID_TOP = '1;

  // Idle percentage of the sender per random phase
  localparam int IDLE_PLAN [4] = '{0, 70, 13, 0};

  typedef struct {
    clia_in_t  item;
    bit        typed;
    clia_out_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  clia_in_t  item_i = '0;
  logic      busy;
  logic      result_valid_o;
  clia_out_t result_o;

  // Predicted request table
  logic [ID_FW-1:0]   tab_id   [ENTRIES];
  logic [NODE_FW-1:0] tab_node [ENTRIES];
  bit                 tab_rtr  [ENTRIES];
  bit                 tab_mark [ENTRIES];
  int                 tab_cnt = 0;
  bit                 tab_idle = 1'b1;
  bit                 tab_err = 1'b0;

  clia_out_t grant_q [$];
  dir_row_t  plan [$];
  int        mis_cnt = 0;
  int        cycles = 0;
  int        idle_pct = 0;
  int        items_sent = 0;

  can_lowest_id_arbiter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Lowest identifier wins; first data entry takes the grant, remotes get marked
  function automatic clia_out_t arbitrate_table();
    clia_out_t r;
    int i;
    int best;
    int win;
    int senders;
    bit got_data;
    r = '0;
    if (tab_cnt == 0) begin
      tab_idle = 1'b1;
      return r;
    end
    best = 0;
    for (i = 1; i < tab_cnt; i++) begin
      if (tab_id[i] < tab_id[best]) best = i;
    end
    win = best;
    senders = 0;
    got_data = 1'b0;
    for (i = 0; i < tab_cnt; i++) begin
      if (tab_id[i] == tab_id[best]) begin
        if (tab_rtr[i]) begin
          tab_mark[i] = 1'b1;
        end else begin
          senders++;
          if (!got_data) begin
            got_data = 1'b1;
            win = i;
            tab_mark[i] = 1'b1;
          end
        end
      end
    end
    r.grant_valid = 1'b1;
    r.grant_id = tab_id[best];
    r.grant_node = tab_node[win];
    r.duplicate_senders = (senders > 1);
    return r;
  endfunction

  // Expected result of one item, updating the predicted table
  function automatic clia_out_t predict_item(input clia_in_t it);
    clia_out_t r;
    int i;
    int w;
    r = '0;
    case (it.kind)
      K_REGISTER: begin
        if (tab_cnt >= ENTRIES) begin
          r.table_full = 1'b1;
        end else begin
          tab_id[tab_cnt] = it.can_id;
          tab_node[tab_cnt] = it.node;
          tab_rtr[tab_cnt] = it.is_remote;
          tab_mark[tab_cnt] = 1'b0;
          tab_cnt++;
          tab_idle = 1'b0;
        end
      end
      K_CHECKOUT: begin
        for (i = 0; i < tab_cnt; i++) begin
          if (tab_id[i] == it.can_id) begin
            for (w = i; w < tab_cnt - 1; w++) begin
              tab_id[w] = tab_id[w + 1];
              tab_node[w] = tab_node[w + 1];
              tab_rtr[w] = tab_rtr[w + 1];
              tab_mark[w] = tab_mark[w + 1];
            end
            tab_cnt--;
            tab_mark[tab_cnt] = 1'b0;
            break;
          end
        end
      end
      K_ARBITRATE: r = arbitrate_table();
      K_COMPLETE: begin
        // compact unmarked entries, keeping their order
        w = 0;
        for (i = 0; i < tab_cnt; i++) begin
          if (!tab_mark[i]) begin
            tab_id[w] = tab_id[i];
            tab_node[w] = tab_node[i];
            tab_rtr[w] = tab_rtr[i];
            w++;
          end
        end
        tab_cnt = w;
        for (i = 0; i < ENTRIES; i++) tab_mark[i] = 1'b0;
        tab_err = 1'b0;
        r = arbitrate_table();
      end
      K_ERROR_END: begin
        for (i = 0; i < ENTRIES; i++) tab_mark[i] = 1'b0;
        tab_err = 1'b0;
        r = arbitrate_table();
      end
      K_ERROR_SEEN: begin
        if (!tab_err) begin
          tab_err = 1'b1;
          r.error_forwarded = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_FW'(tab_cnt);
    r.bus_idle = tab_idle;
    return r;
  endfunction

  function automatic clia_in_t mk(input logic [KIND_FW-1:0] kind,
                                  input logic [ID_FW-1:0] id,
                                  input logic [NODE_FW-1:0] node, input logic rtr);
    clia_in_t it;
    it.kind = kind;
    it.can_id = id;
    it.node = node;
    it.is_remote = rtr;
    return it;
  endfunction

  function automatic clia_out_t status(input bit fwd, input int cnt, input bit idle);
    clia_out_t r;
    r = '0;
    r.error_forwarded = fwd;
    r.entry_count = CNT_FW'(cnt);
    r.bus_idle = idle;
    return r;
  endfunction

  function automatic clia_out_t granted(input logic [ID_FW-1:0] id,
                                        input logic [NODE_FW-1:0] node, input int cnt);
    clia_out_t r;
    r = status(1'b0, cnt, 1'b0);
    r.grant_valid = 1'b1;
    r.grant_id = id;
    r.grant_node = node;
    return r;
  endfunction

  function automatic dir_row_t row(input clia_in_t it, input bit typed,
                                   input clia_out_t want);
    dir_row_t d;
    d.item = it;
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input clia_in_t it, input bit typed,
                                  input clia_out_t want);
    plan.insert(plan.size(), row(it, typed, want));
  endfunction

  // Mostly a small pool so identifiers collide, sometimes extremes or any value
  function automatic logic [ID_FW-1:0] pick_id();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return ID_FW'($urandom_range(0, 7));
    if (sel < 60 && tab_cnt > 0) return tab_id[$urandom_range(0, tab_cnt - 1)];
    if (sel < 62) return '0;
    if (sel < 65) return ID_TOP;
    return ID_FW'($urandom());
  endfunction

  // Present one item from a falling edge and hold it until accepted
  task automatic send_item(input clia_in_t it, input bit typed, input clia_out_t want);
    clia_out_t r;
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = predict_item(it);
    grant_q.insert(grant_q.size(), typed ? want : r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send(input clia_in_t it);
    send_item(it, 1'b0, '0);
  endtask

  // Hold the sender off until every pending result has come out
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (grant_q.size() != 0);
  endtask

  task automatic flag(input string what, input logic [ID_FW-1:0] e,
                      input logic [ID_FW-1:0] a);
    mis_cnt++;
    if (mis_cnt <= MAX_REPORTS)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, e, a);
  endtask

  // Result checker, compares against the oldest expectation
  always @(posedge clk_i) begin : chk_results
    clia_out_t want;
    if (rst_ni && result_valid_o) begin
      if (grant_q.size() == 0) begin
        flag("unexpected result, grant_id", '0, result_o.grant_id);
      end else begin
        want = grant_q.pop_front();
        if (want.grant_valid !== result_o.grant_valid)
          flag("grant_valid", want.grant_valid, result_o.grant_valid);
        if (want.grant_id !== result_o.grant_id)
          flag("grant_id", want.grant_id, result_o.grant_id);
        if (want.grant_node !== result_o.grant_node)
          flag("grant_node", want.grant_node, result_o.grant_node);
        if (want.duplicate_senders !== result_o.duplicate_senders)
          flag("duplicate_senders", want.duplicate_senders, result_o.duplicate_senders);
        if (want.error_forwarded !== result_o.error_forwarded)
          flag("error_forwarded", want.error_forwarded, result_o.error_forwarded);
        if (want.table_full !== result_o.table_full)
          flag("table_full", want.table_full, result_o.table_full);
        if (want.entry_count !== result_o.entry_count)
          flag("entry_count", want.entry_count, result_o.entry_count);
        if (want.bus_idle !== result_o.bus_idle)
          flag("bus_idle", want.bus_idle, result_o.bus_idle);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int n;
    int ph;
    int sel;
    clia_out_t dup_grant;
    for (i = 0; i < ENTRIES; i++) tab_mark[i] = 1'b0;

    // Directed table
    add_row(mk(K_ARBITRATE, '0, '0, 1'b0), 1'b1, status(1'b0, 0, 1'b1));
    add_row(mk(K_ERROR_SEEN, '0, '0, 1'b0), 1'b1, status(1'b1, 0, 1'b1));
    add_row(mk(K_ERROR_SEEN, '0, '0, 1'b0), 1'b1, status(1'b0, 0, 1'b1));
    add_row(mk(K_SPARE_6, ID_TOP, 4'hF, 1'b1), 1'b1, status(1'b0, 0, 1'b1));
    add_row(mk(K_SPARE_7, '0, '0, 1'b0), 1'b1, status(1'b0, 0, 1'b1));
    add_row(mk(K_COMPLETE, '0, '0, 1'b0), 1'b1, status(1'b0, 0, 1'b1));
    add_row(mk(K_ERROR_END, '0, '0, 1'b0), 1'b1, status(1'b0, 0, 1'b1));
    add_row(mk(K_REGISTER, ID_TOP, 4'hF, 1'b0), 1'b1, status(1'b0, 1, 1'b0));
    add_row(mk(K_REGISTER, '0, 4'h0, 1'b1), 1'b1, status(1'b0, 2, 1'b0));
    // lone remote entry at the lowest identifier takes the grant
    add_row(mk(K_ARBITRATE, '0, '0, 1'b0), 1'b1, granted('0, 4'h0, 2));
    // marking twice changes nothing
    add_row(mk(K_ARBITRATE, '0, '0, 1'b0), 1'b1, granted('0, 4'h0, 2));
    add_row(mk(K_REGISTER, '0, 4'h5, 1'b0), 1'b1, status(1'b0, 3, 1'b0));
    add_row(mk(K_REGISTER, '0, 4'h9, 1'b0), 1'b1, status(1'b0, 4, 1'b0));
    // two data senders at identifier zero
    dup_grant = granted('0, 4'h5, 4);
    dup_grant.duplicate_senders = 1'b1;
    add_row(mk(K_ARBITRATE, '0, '0, 1'b0), 1'b1, dup_grant);
    add_row(mk(K_ERROR_END, '0, '0, 1'b0), 1'b0, '0);
    add_row(mk(K_ERROR_SEEN, '0, '0, 1'b0), 1'b1, status(1'b1, 4, 1'b0));
    add_row(mk(K_COMPLETE, '0, '0, 1'b0), 1'b0, '0);
    add_row(mk(K_CHECKOUT, 29'd12345, '0, 1'b0), 1'b0, '0);
    add_row(mk(K_CHECKOUT, ID_TOP, '0, 1'b0), 1'b0, '0);
    add_row(mk(K_REGISTER, 29'h0AAAAAAA, 4'hA, 1'b0), 1'b0, '0);
    add_row(mk(K_REGISTER, 29'h15555555, 4'h5, 1'b1), 1'b0, '0);
    add_row(mk(K_ARBITRATE, '0, '0, 1'b0), 1'b0, '0);
    add_row(mk(K_COMPLETE, '0, '0, 1'b0), 1'b0, '0);
    add_row(mk(K_COMPLETE, '0, '0, 1'b0), 1'b0, '0);
    add_row(mk(K_CHECKOUT, 29'h0AAAAAAA, '0, 1'b0), 1'b0, '0);

    // Reset
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 13;
    foreach (plan[k]) send_item(plan[k].item, plan[k].typed, plan[k].want);

    // Random frame traffic, in phases of differing sender idling
    items_sent = 0;
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = IDLE_PLAN[ph];
      wait_drained();
      while (items_sent < (ph + 1) * RAND_ITEMS / 4) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          // fill the table and push past full
          n = ENTRIES - tab_cnt + $urandom_range(1, 2);
          repeat (n) send(mk(K_REGISTER, pick_id(), NODE_FW'($urandom()), 1'($urandom())));
        end else if (sel < 18) begin
          // withdraw requests, now and then an identifier that is absent
          n = $urandom_range(1, tab_cnt + 1);
          repeat (n) begin
            if (tab_cnt > 0 && $urandom_range(0, 9) != 0)
              send(mk(K_CHECKOUT, tab_id[$urandom_range(0, tab_cnt - 1)], '0, 1'b0));
            else
              send(mk(K_CHECKOUT, pick_id(), NODE_FW'($urandom()), 1'($urandom())));
          end
        end else if (sel < 80) begin
          // one bus frame: requests, arbitration, then success or error
          n = $urandom_range(0, 2);
          repeat (n) send(mk(K_REGISTER, pick_id(), NODE_FW'($urandom()), 1'($urandom())));
          send(mk(K_ARBITRATE, pick_id(), '0, 1'b0));
          if ($urandom_range(0, 4) == 0) send(mk(K_ARBITRATE, '0, '0, 1'b0));
          if ($urandom_range(0, 3) == 0) begin
            send(mk(K_ERROR_SEEN, '0, '0, 1'b0));
            if ($urandom_range(0, 1) == 0) send(mk(K_ERROR_SEEN, '0, '0, 1'b0));
            send(mk(K_ERROR_END, '0, '0, 1'b0));
          end else begin
            send(mk(K_COMPLETE, '0, '0, 1'b0));
          end
        end else begin
          // noise: any kind, any fields
          n = $urandom_range(1, 5);
          repeat (n) send(mk(KIND_FW'($urandom_range(0, 7)), ID_FW'($urandom()),
                             NODE_FW'($urandom()), 1'($urandom())));
        end
      end
    end

    // Drain and settle
    start <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mis_cnt == 0 && grant_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
